// ===== src/wsva_pkg.sv =====
// shared types, sizes and helpers for the window stack visible area block
// used by every module of the block; depends on nothing
`default_nettype none

package wsva_pkg;

    localparam int MAX_WINDOWS = 16;
    localparam int ID_COUNT    = 256;
    localparam int COORD_BITS  = 15;
    localparam int IDX_W       = $clog2(MAX_WINDOWS);
    localparam int CNT_W       = $clog2(MAX_WINDOWS + 1);
    localparam int PEND_DEPTH  = 3 * MAX_WINDOWS + 1;
    localparam int SP_W        = $clog2(PEND_DEPTH + 1);
    localparam int ADDR_W      = $clog2(PEND_DEPTH);
    localparam int AREA_W      = 30;
    localparam int PCT_W       = 17;
    localparam int MUL_A_W     = 30;
    localparam int MUL_B_W     = 18;
    localparam int MUL_W       = MUL_A_W + MUL_B_W;
    localparam int DEN_W       = AREA_W + 1;
    localparam int DIV_STEPS   = MUL_W;
    localparam int STEP_W      = $clog2(DIV_STEPS + 1);
    localparam logic [MUL_B_W-1:0] PCT_SCALE = MUL_B_W'(200000);

    // command codes
    localparam logic [2:0] CMD_CREATE  = 3'd0;
    localparam logic [2:0] CMD_RAISE   = 3'd1;
    localparam logic [2:0] CMD_LOWER   = 3'd2;
    localparam logic [2:0] CMD_DESTROY = 3'd3;
    localparam logic [2:0] CMD_QUERY   = 3'd4;

    typedef struct packed {
        logic [COORD_BITS-1:0] y2;
        logic [COORD_BITS-1:0] x2;
        logic [COORD_BITS-1:0] y1;
        logic [COORD_BITS-1:0] x1;
    } rect_t;

    typedef struct packed {
        logic [CNT_W-1:0] lvl;
        rect_t            r;
    } pend_t;

    typedef struct packed {
        logic              start;
        logic [MUL_W-1:0]  num;
        logic [DEN_W-1:0]  den;
    } div_req_t;

    function automatic logic [COORD_BITS-1:0] cmin(input logic [COORD_BITS-1:0] a,
                                                  input logic [COORD_BITS-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [COORD_BITS-1:0] cmax(input logic [COORD_BITS-1:0] a,
                                                  input logic [COORD_BITS-1:0] b);
        return (a > b) ? a : b;
    endfunction

endpackage

`default_nettype wire

// ===== src/window_stack_visible_area_core.sv =====
// top level: window stack, command sequencer and visible area query engine
// depends on wsva_pkg, wsva_pend_mem and wsva_div
`default_nettype none

// Keeps a z-ordered stack of up to 16 windows and answers visible area queries.
// One request is taken at a time; s_tready is high only while the sequencer is
// idle. Every valid command first searches the stack one entry per cycle, then
// create, raise, lower and destroy move one stack entry per cycle and finish in
// the finish state. A query pops one pending piece from the work stack memory
// (pop, then evaluate), adds a fully visible piece in the accumulate state and
// pushes the pieces of a split one by one, shares one 30x18 multiplier for areas
// and scaling, and ends with a 48-step bit-serial divide, skipped for a window of
// zero area. Only queries produce a result; it sits in an output register until
// taken.
module window_stack_visible_area_core
    import wsva_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // command[2:0], window_id[10:3], corner_ax[25:11], corner_ay[40:26],
    // corner_bx[55:41], corner_by[70:56], zero fill[71]
    input  wire logic [71:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // found[0], visible_area[30:1], total_area[60:31], percent_milli[77:61],
    // zero fill[79:78]
    output logic [79:0]      m_tdata
);

    typedef enum logic [14:0] {
        ST_IDLE   = 15'b000000000000001,
        ST_SEARCH = 15'b000000000000010,
        ST_SHDN   = 15'b000000000000100,
        ST_SHUP   = 15'b000000000001000,
        ST_FIN    = 15'b000000000010000,
        ST_QINIT  = 15'b000000000100000,
        ST_QTOT   = 15'b000000001000000,
        ST_QPOP   = 15'b000000010000000,
        ST_QEVAL  = 15'b000000100000000,
        ST_QPUSH  = 15'b000001000000000,
        ST_QACC   = 15'b000010000000000,
        ST_QSCALE = 15'b000100000000000,
        ST_QDIVLD = 15'b001000000000000,
        ST_QDIV   = 15'b010000000000000,
        ST_OUT    = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [2:0]        cmd_reg, cmd_next;
    logic [7:0]        id_reg, id_next;
    rect_t             hold_reg, hold_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [ID_COUNT-1:0] pres_reg, pres_next;
    logic [SP_W-1:0]   sp_reg, sp_next;
    logic [1:0]        k_reg, k_next;
    rect_t             piece_reg [4];
    rect_t             piece_next [4];
    logic [CNT_W-1:0]  plvl_reg, plvl_next;
    logic [AREA_W-1:0] area_reg, area_next;
    logic [AREA_W-1:0] tot_reg, tot_next;
    logic [MUL_W-1:0]  mul_reg;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;

    logic [7:0]        ord_id_reg   [MAX_WINDOWS];
    rect_t             ord_rect_reg [MAX_WINDOWS];

    logic              res_found_reg, res_found_next;
    logic [AREA_W-1:0] res_vis_reg, res_vis_next;
    logic [PCT_W-1:0]  res_pct_reg, res_pct_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [79:0]       m_tdata_reg, m_tdata_next;

    // stack write port and read select
    logic              st_we;
    logic [IDX_W-1:0]  st_waddr;
    logic [7:0]        st_wid;
    rect_t             st_wrect;
    logic [IDX_W-1:0]  st_raddr;
    logic [7:0]        rd_id;
    rect_t             rd_rect;

    // work stack ports
    logic              pm_we;
    logic [ADDR_W-1:0] pm_waddr;
    pend_t             pm_wdata;
    logic              pm_re;
    logic [ADDR_W-1:0] pm_raddr;
    pend_t             pm_rdata;

    div_req_t          div_req;
    logic              div_busy;
    logic              div_done;
    logic [PCT_W-1:0]  div_quo;

    // request fields
    logic [2:0]            in_cmd;
    logic [7:0]            in_id;
    logic [COORD_BITS-1:0] in_ax, in_ay, in_bx, in_by;

    // split pieces against the covering window
    rect_t             cur_r, win_r;
    rect_t             cand [4];
    logic              disjoint, covered;
    logic [COORD_BITS-1:0] min_x2, min_y2, max_x1, max_y1;

    assign in_cmd = s_tdata[2:0];
    assign in_id  = s_tdata[10:3];
    assign in_ax  = s_tdata[25:11];
    assign in_ay  = s_tdata[40:26];
    assign in_bx  = s_tdata[55:41];
    assign in_by  = s_tdata[70:56];

    assign rd_id   = ord_id_reg[st_raddr];
    assign rd_rect = ord_rect_reg[st_raddr];

    assign cur_r  = pm_rdata.r;
    assign win_r  = rd_rect;
    assign min_x2 = cmin(cur_r.x2, win_r.x2);
    assign min_y2 = cmin(cur_r.y2, win_r.y2);
    assign max_x1 = cmax(cur_r.x1, win_r.x1);
    assign max_y1 = cmax(cur_r.y1, win_r.y1);
    assign disjoint = (win_r.x2 < cur_r.x1) || (win_r.x1 > cur_r.x2) ||
                      (win_r.y2 < cur_r.y1) || (win_r.y1 > cur_r.y2);
    assign covered  = (win_r.x1 <= cur_r.x1) && (win_r.y1 <= cur_r.y1) &&
                      (cur_r.x2 <= win_r.x2) && (cur_r.y2 <= win_r.y2);

    // up, right, down, left pieces in push order
    always_comb
    begin
        cand[0] = '{x1: cur_r.x1, y1: min_y2, x2: min_x2, y2: cur_r.y2};
        cand[1] = '{x1: min_x2, y1: max_y1, x2: cur_r.x2, y2: cur_r.y2};
        cand[2] = '{x1: max_x1, y1: cur_r.y1, x2: cur_r.x2, y2: max_y1};
        cand[3] = '{x1: cur_r.x1, y1: cur_r.y1, x2: max_x1, y2: min_y2};
    end

    // read address select
    always_comb
    begin
        case (state_reg)
            ST_SHDN:  st_raddr = IDX_W'(idx_reg - 1'b1);
            ST_SHUP:  st_raddr = IDX_W'(idx_reg + 1'b1);
            ST_QEVAL: st_raddr = IDX_W'(pm_rdata.lvl - 1'b1);
            default:  st_raddr = idx_reg[IDX_W-1:0];
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        id_next        = id_reg;
        hold_next      = hold_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        pres_next      = pres_reg;
        sp_next        = sp_reg;
        k_next         = k_reg;
        plvl_next      = plvl_reg;
        area_next      = area_reg;
        tot_next       = tot_reg;
        res_found_next = res_found_reg;
        res_vis_next   = res_vis_reg;
        res_pct_next   = res_pct_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        for (int n = 0; n < 4; n++)
        begin
            piece_next[n] = piece_reg[n];
        end
        st_we    = 1'b0;
        st_waddr = idx_reg[IDX_W-1:0];
        st_wid   = id_reg;
        st_wrect = hold_reg;
        pm_we    = 1'b0;
        pm_waddr = sp_reg[ADDR_W-1:0];
        pm_wdata = '{lvl: plvl_reg, r: piece_reg[k_reg]};
        pm_re    = 1'b0;
        pm_raddr = ADDR_W'(sp_reg - 1'b1);
        mul_a    = MUL_A_W'(hold_reg.x2 - hold_reg.x1);
        mul_b    = MUL_B_W'(hold_reg.y2 - hold_reg.y1);
        div_req  = '{start: 1'b0, num: MUL_W'(mul_reg + MUL_W'(tot_reg)),
                     den: {tot_reg, 1'b0}};

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next  = in_cmd;
                    id_next   = in_id;
                    idx_next  = '0;
                    hold_next = '{x1: cmin(in_ax, in_bx), y1: cmin(in_ay, in_by),
                                  x2: cmax(in_ax, in_bx), y2: cmax(in_ay, in_by)};
                    if (in_cmd <= CMD_QUERY)
                    begin
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (!pres_reg[id_reg])
                begin
                    // absent id
                    if (cmd_reg == CMD_CREATE && cnt_reg < CNT_W'(MAX_WINDOWS))
                    begin
                        idx_next   = cnt_reg;
                        state_next = ST_SHDN;
                    end
                    else if (cmd_reg == CMD_QUERY)
                    begin
                        res_found_next = 1'b0;
                        res_vis_next   = '0;
                        tot_next       = '0;
                        res_pct_next   = '0;
                        state_next     = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (rd_id == id_reg)
                begin
                    hold_next = rd_rect;
                    case (cmd_reg)
                        CMD_RAISE:   state_next = ST_SHDN;
                        CMD_LOWER,
                        CMD_DESTROY: state_next = ST_SHUP;
                        CMD_QUERY:   state_next = ST_QINIT;
                        default:
                        begin
                            // duplicate create
                            hold_next  = hold_reg;
                            state_next = ST_IDLE;
                        end
                    endcase
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_SHDN:
            begin
                if (idx_reg == '0)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    st_we    = 1'b1;
                    st_wid   = rd_id;
                    st_wrect = rd_rect;
                    idx_next = idx_reg - 1'b1;
                end
            end
            ST_SHUP:
            begin
                if (CNT_W'(idx_reg + 1'b1) >= cnt_reg)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    st_we    = 1'b1;
                    st_wid   = rd_id;
                    st_wrect = rd_rect;
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_FIN:
            begin
                state_next = ST_IDLE;
                case (cmd_reg)
                    CMD_CREATE:
                    begin
                        st_we             = 1'b1;
                        st_waddr          = '0;
                        cnt_next          = cnt_reg + 1'b1;
                        pres_next[id_reg] = 1'b1;
                    end
                    CMD_RAISE:
                    begin
                        st_we    = 1'b1;
                        st_waddr = '0;
                    end
                    CMD_LOWER:
                    begin
                        st_we    = 1'b1;
                        st_waddr = IDX_W'(cnt_reg - 1'b1);
                    end
                    default:
                    begin
                        cnt_next          = cnt_reg - 1'b1;
                        pres_next[id_reg] = 1'b0;
                    end
                endcase
            end
            ST_QINIT:
            begin
                // total area on the multiplier, seed the work stack
                area_next = '0;
                pm_waddr  = '0;
                pm_wdata  = '{lvl: idx_reg, r: hold_reg};
                if (hold_reg.x1 < hold_reg.x2 && hold_reg.y1 < hold_reg.y2)
                begin
                    pm_we   = 1'b1;
                    sp_next = SP_W'(1);
                end
                else
                begin
                    sp_next = '0;
                end
                state_next = ST_QTOT;
            end
            ST_QTOT:
            begin
                tot_next   = mul_reg[AREA_W-1:0];
                state_next = ST_QPOP;
            end
            ST_QPOP:
            begin
                if (sp_reg == '0)
                begin
                    state_next = ST_QSCALE;
                end
                else
                begin
                    pm_re      = 1'b1;
                    sp_next    = sp_reg - 1'b1;
                    state_next = ST_QEVAL;
                end
            end
            ST_QEVAL:
            begin
                mul_a     = MUL_A_W'(cur_r.x2 - cur_r.x1);
                mul_b     = MUL_B_W'(cur_r.y2 - cur_r.y1);
                plvl_next = pm_rdata.lvl - 1'b1;
                if (pm_rdata.lvl == '0)
                begin
                    state_next = ST_QACC;
                end
                else if (disjoint)
                begin
                    pm_we      = 1'b1;
                    pm_wdata   = '{lvl: CNT_W'(pm_rdata.lvl - 1'b1), r: cur_r};
                    sp_next    = sp_reg + 1'b1;
                    state_next = ST_QPOP;
                end
                else if (covered)
                begin
                    state_next = ST_QPOP;
                end
                else
                begin
                    for (int n = 0; n < 4; n++)
                    begin
                        piece_next[n] = cand[n];
                    end
                    k_next     = '0;
                    state_next = ST_QPUSH;
                end
            end
            ST_QPUSH:
            begin
                if (piece_reg[k_reg].x1 < piece_reg[k_reg].x2 &&
                    piece_reg[k_reg].y1 < piece_reg[k_reg].y2)
                begin
                    pm_we   = 1'b1;
                    sp_next = sp_reg + 1'b1;
                end
                k_next = k_reg + 1'b1;
                if (k_reg == 2'd3)
                begin
                    state_next = ST_QPOP;
                end
            end
            ST_QACC:
            begin
                area_next  = AREA_W'(area_reg + mul_reg[AREA_W-1:0]);
                state_next = ST_QPOP;
            end
            ST_QSCALE:
            begin
                mul_a      = area_reg;
                mul_b      = PCT_SCALE;
                state_next = ST_QDIVLD;
            end
            ST_QDIVLD:
            begin
                res_found_next = 1'b1;
                res_vis_next   = area_reg;
                if (tot_reg == '0)
                begin
                    res_pct_next = '0;
                    state_next   = ST_OUT;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = ST_QDIV;
                end
            end
            ST_QDIV:
            begin
                if (div_done)
                begin
                    res_pct_next = div_quo;
                    state_next   = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {2'b00, res_pct_reg, tot_reg, res_vis_reg,
                                     res_found_reg};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            pres_reg     <= '0;
            sp_reg       <= '0;
            k_reg        <= '0;
            idx_reg      <= '0;
            area_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            pres_reg     <= pres_next;
            sp_reg       <= sp_next;
            k_reg        <= k_next;
            idx_reg      <= idx_next;
            area_reg     <= area_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers and the shared multiplier
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        id_reg        <= id_next;
        hold_reg      <= hold_next;
        plvl_reg      <= plvl_next;
        tot_reg       <= tot_next;
        res_found_reg <= res_found_next;
        res_vis_reg   <= res_vis_next;
        res_pct_reg   <= res_pct_next;
        m_tdata_reg   <= m_tdata_next;
        mul_reg       <= mul_a * mul_b;
        for (int n = 0; n < 4; n++)
        begin
            piece_reg[n] <= piece_next[n];
        end
    end

    // window stack storage
    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            ord_id_reg[st_waddr]   <= st_wid;
            ord_rect_reg[st_waddr] <= st_wrect;
        end
    end

    wsva_pend_mem u_pend (
        .clk   (clk),
        .we    (pm_we),
        .waddr (pm_waddr),
        .wdata (pm_wdata),
        .re    (pm_re),
        .raddr (pm_raddr),
        .rdata (pm_rdata)
    );

    wsva_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .busy  (div_busy),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // window count stays within the stack
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_WINDOWS))
        else $error("window count beyond stack depth");

    // work stack never overflows
    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_W'(PEND_DEPTH))
        else $error("work stack overflow");

    // divider is started only when free
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_busy)
        else $error("divider started while busy");

    // a result is loaded only from the result state
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_tvalid_reg && m_tvalid_next) |-> (state_reg == ST_OUT))
        else $error("result loaded outside result state");

endmodule

`default_nettype wire

// ===== src/wsva_pend_mem.sv =====
// work stack memory for pending query pieces, one write and one registered read
// depends on wsva_pkg
`default_nettype none

module wsva_pend_mem
    import wsva_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire pend_t             wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output pend_t                  rdata
);

    pend_t mem [PEND_DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/wsva_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on wsva_pkg
`default_nettype none

module wsva_div
    import wsva_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire div_req_t         req,
    output logic                  busy,
    output logic                  done,
    output logic [PCT_W-1:0]      quo
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [MUL_W-1:0]  num_reg, num_next;
    logic [MUL_W-1:0]  quo_reg, quo_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [DEN_W:0]    rem_sh;

    // load on start, else one shift and subtract step while busy
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        num_next  = num_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        rem_sh    = {rem_reg, num_reg[MUL_W-1]};
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            num_next  = req.num;
            den_next  = req.den;
            rem_next  = '0;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[MUL_W-2:0], 1'b0};
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_next = DEN_W'(rem_sh - {1'b0, den_reg});
                quo_next = {quo_reg[MUL_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[DEN_W-1:0];
                quo_next = {quo_reg[MUL_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = quo_reg[PCT_W-1:0];

endmodule

`default_nettype wire

// ===== tb/window_stack_visible_area_core_tb.sv =====
// testbench for the window stack visible area block: directed and random commands
// checked against a behavioral model of the stack; depends on wsva_pkg and the rtl
`default_nettype none

module window_stack_visible_area_core_tb;
    import wsva_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint CYCLE_LIMIT = 20000000;

    typedef struct {
        logic [2:0]  command;
        logic [7:0]  window_id;
        logic [14:0] ax, ay, bx, by;
    } request_t;

    typedef struct {
        logic        found;
        logic [29:0] visible_area;
        logic [29:0] total_area;
        logic [16:0] percent_milli;
    } answer_t;

    typedef struct {
        int unsigned x1, y1, x2, y2;
    } box_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;

    // stack model, index 0 is the top
    logic [7:0]  stack_ids [MAX_WINDOWS];
    box_t        stack_boxes [MAX_WINDOWS];
    int          stack_depth = 0;
    bit          is_present [ID_COUNT];

    // newest answer at the front, oldest at the back
    answer_t     expected_answers [$];
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          hold_off = 1'b0;
    int          fail_count = 0;
    int          answer_count = 0;
    int          request_count = 0;
    longint      cycle_count = 0;

    window_stack_visible_area_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("window_stack_visible_area_core verification failed");
            $finish;
        end
    end

    function automatic int locate(input logic [7:0] id);
        if (!is_present[id])
            return -1;
        for (int i = 0; i < stack_depth; i++)
            if (stack_ids[i] == id)
                return i;
        return -1;
    endfunction

    // uncovered area by splitting against each higher window, explicit stack
    function automatic longint unsigned uncovered_area(input int pos);
        box_t        pieces [$];
        int          levels [$];
        box_t        r, w;
        int          lvl;
        longint unsigned total;
        total = 0;
        pieces.push_front(stack_boxes[pos]);
        levels.push_front(pos);
        while (pieces.size() > 0)
        begin
            r = pieces.pop_front();
            lvl = levels.pop_front();
            if (r.x1 >= r.x2 || r.y1 >= r.y2)
                continue;
            if (lvl == 0)
            begin
                total += longint'(r.x2 - r.x1) * longint'(r.y2 - r.y1);
                continue;
            end
            w = stack_boxes[lvl - 1];
            if (w.x2 < r.x1 || w.x1 > r.x2 || w.y2 < r.y1 || w.y1 > r.y2)
            begin
                pieces.push_front(r);
                levels.push_front(lvl - 1);
                continue;
            end
            if (w.x1 <= r.x1 && w.y1 <= r.y1 && r.x2 <= w.x2 && r.y2 <= w.y2)
                continue;
            pieces.push_front('{r.x1, (r.y2 < w.y2) ? r.y2 : w.y2,
                                (r.x2 < w.x2) ? r.x2 : w.x2, r.y2});
            pieces.push_front('{(r.x2 < w.x2) ? r.x2 : w.x2,
                                (r.y1 > w.y1) ? r.y1 : w.y1, r.x2, r.y2});
            pieces.push_front('{(r.x1 > w.x1) ? r.x1 : w.x1, r.y1, r.x2,
                                (r.y1 > w.y1) ? r.y1 : w.y1});
            pieces.push_front('{r.x1, r.y1, (r.x1 > w.x1) ? r.x1 : w.x1,
                                (r.y2 < w.y2) ? r.y2 : w.y2});
            repeat (4)
                levels.push_front(lvl - 1);
        end
        return total;
    endfunction

    // update the stack model for one request, queue an answer for a query
    task automatic apply_command(input request_t q);
        int       pos;
        box_t     moved;
        logic [7:0] mid;
        answer_t  a;
        longint unsigned tot, vis, pct;
        pos = locate(q.window_id);
        case (q.command)
            CMD_CREATE:
            begin
                if (is_present[q.window_id] || stack_depth >= MAX_WINDOWS)
                    return;
                for (int i = stack_depth; i > 0; i--)
                begin
                    stack_ids[i] = stack_ids[i - 1];
                    stack_boxes[i] = stack_boxes[i - 1];
                end
                stack_ids[0] = q.window_id;
                stack_boxes[0] = '{(q.ax < q.bx) ? q.ax : q.bx, (q.ay < q.by) ? q.ay : q.by,
                                   (q.ax > q.bx) ? q.ax : q.bx, (q.ay > q.by) ? q.ay : q.by};
                stack_depth++;
                is_present[q.window_id] = 1'b1;
            end
            CMD_QUERY:
            begin
                a = '{1'b0, '0, '0, '0};
                if (pos >= 0)
                begin
                    tot = longint'(stack_boxes[pos].x2 - stack_boxes[pos].x1) *
                          longint'(stack_boxes[pos].y2 - stack_boxes[pos].y1);
                    vis = uncovered_area(pos);
                    pct = (tot != 0) ? (vis * 200000 + tot) / (2 * tot) : 0;
                    a = '{1'b1, vis[29:0], tot[29:0], pct[16:0]};
                end
                expected_answers.push_front(a);
            end
            CMD_RAISE, CMD_LOWER, CMD_DESTROY:
            begin
                if (pos < 0)
                    return;
                mid = stack_ids[pos];
                moved = stack_boxes[pos];
                if (q.command == CMD_RAISE)
                begin
                    for (int i = pos; i > 0; i--)
                    begin
                        stack_ids[i] = stack_ids[i - 1];
                        stack_boxes[i] = stack_boxes[i - 1];
                    end
                    stack_ids[0] = mid;
                    stack_boxes[0] = moved;
                end
                else
                begin
                    for (int i = pos; i + 1 < stack_depth; i++)
                    begin
                        stack_ids[i] = stack_ids[i + 1];
                        stack_boxes[i] = stack_boxes[i + 1];
                    end
                    if (q.command == CMD_LOWER)
                    begin
                        stack_ids[stack_depth - 1] = mid;
                        stack_boxes[stack_depth - 1] = moved;
                    end
                    else
                    begin
                        stack_depth--;
                        is_present[q.window_id] = 1'b0;
                    end
                end
            end
            default:
                ;
        endcase
    endtask

    // offer one request, with random idle gaps before it
    task automatic send_request(input request_t q);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, q.by, q.bx, q.ay, q.ax, q.window_id, q.command};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        apply_command(q);
        request_count++;
    endtask

    task automatic go_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    // receiver ready with random stalls and an optional long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end

    // check each answer against the oldest expectation
    always @(posedge clk)
    begin
        answer_t a, e;
        if (rst_n && m_tvalid && m_tready)
        begin
            a = '{m_tdata[0], m_tdata[30:1], m_tdata[60:31], m_tdata[77:61]};
            answer_count++;
            if (expected_answers.size() == 0)
            begin
                $display("%0t: unexpected answer %h", $time, m_tdata);
                fail_count++;
            end
            else
            begin
                e = expected_answers.pop_back();
                if (a.found != e.found)
                begin
                    $display("%0t: found exp %0d got %0d", $time, e.found, a.found);
                    fail_count++;
                end
                if (a.visible_area != e.visible_area)
                begin
                    $display("%0t: visible exp %0d got %0d", $time, e.visible_area,
                             a.visible_area);
                    fail_count++;
                end
                if (a.total_area != e.total_area)
                begin
                    $display("%0t: total exp %0d got %0d", $time, e.total_area,
                             a.total_area);
                    fail_count++;
                end
                if (a.percent_milli != e.percent_milli)
                begin
                    $display("%0t: percent exp %0d got %0d", $time, e.percent_milli,
                             a.percent_milli);
                    fail_count++;
                end
            end
        end
    end

    function automatic request_t make_request(input logic [2:0] c, input logic [7:0] id,
                                              input int ax, input int ay, input int bx,
                                              input int by);
        request_t q;
        q = '{c, id, ax[14:0], ay[14:0], bx[14:0], by[14:0]};
        return q;
    endfunction

    // coordinate, mostly within a small area so windows overlap
    function automatic int rand_coord();
        case ($urandom_range(9))
            0: return $urandom_range(32767);
            1: return 32767 - $urandom_range(3);
            2: return $urandom_range(3);
            default: return $urandom_range(60);
        endcase
    endfunction

    // id, mostly from a small pool so commands hit existing windows
    function automatic logic [7:0] rand_id();
        if ($urandom_range(9) == 0)
            return 8'($urandom_range(255));
        return 8'($urandom_range(23) + (($urandom_range(1) != 0) ? 8'd232 : 8'd0));
    endfunction

    // extremes, every command and every special case
    task automatic test_directed();
        send_request(make_request(CMD_QUERY, 8'd0, 0, 0, 0, 0));
        send_request(make_request(CMD_CREATE, 8'd0, 32767, 32767, 0, 0));
        send_request(make_request(CMD_QUERY, 8'd0, 0, 0, 0, 0));
        send_request(make_request(CMD_CREATE, 8'd0, 1, 1, 2, 2));
        send_request(make_request(CMD_CREATE, 8'd255, 10, 10, 10, 500));
        send_request(make_request(CMD_QUERY, 8'd255, 0, 0, 0, 0));
        send_request(make_request(CMD_CREATE, 8'd7, 100, 200, 300, 400));
        send_request(make_request(CMD_CREATE, 8'd8, 300, 400, 500, 600));
        send_request(make_request(CMD_QUERY, 8'd7, 0, 0, 0, 0));
        send_request(make_request(CMD_CREATE, 8'd9, 150, 250, 250, 350));
        send_request(make_request(CMD_QUERY, 8'd7, 0, 0, 0, 0));
        send_request(make_request(CMD_QUERY, 8'd0, 0, 0, 0, 0));
        send_request(make_request(CMD_LOWER, 8'd9, 0, 0, 0, 0));
        send_request(make_request(CMD_RAISE, 8'd0, 0, 0, 0, 0));
        send_request(make_request(CMD_QUERY, 8'd7, 0, 0, 0, 0));
        send_request(make_request(CMD_RAISE, 8'd77, 0, 0, 0, 0));
        send_request(make_request(CMD_LOWER, 8'd77, 0, 0, 0, 0));
        send_request(make_request(CMD_DESTROY, 8'd77, 0, 0, 0, 0));
        send_request(make_request(3'd5, 8'd7, 0, 0, 0, 0));
        send_request(make_request(3'd6, 8'd7, 0, 0, 0, 0));
        send_request(make_request(3'd7, 8'd7, 32767, 32767, 32767, 32767));
        send_request(make_request(CMD_DESTROY, 8'd0, 0, 0, 0, 0));
        send_request(make_request(CMD_QUERY, 8'd0, 0, 0, 0, 0));
        // fill the stack past its capacity
        for (int i = 0; i < MAX_WINDOWS + 2; i++)
            send_request(make_request(CMD_CREATE, 8'(100 + i), i, i, 40 + i, 40 - i));
        send_request(make_request(CMD_QUERY, 8'd8, 0, 0, 0, 0));
        send_request(make_request(CMD_QUERY, 8'd117, 0, 0, 0, 0));
    endtask

    // mixed commands, queries the most common, over a stack kept near full, plus noise
    task automatic test_random(input int count);
        request_t q;
        int       roll;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(99);
            if (roll < 30)
                q = make_request(CMD_CREATE, rand_id(), rand_coord(), rand_coord(),
                                 rand_coord(), rand_coord());
            else if (roll < 40)
                q = make_request(CMD_RAISE, rand_id(), 0, 0, 0, 0);
            else if (roll < 50)
                q = make_request(CMD_LOWER, rand_id(), 0, 0, 0, 0);
            else if (roll < 62)
                q = make_request(CMD_DESTROY, rand_id(), 0, 0, 0, 0);
            else if (roll < 97)
                q = make_request(CMD_QUERY, rand_id(), 0, 0, 0, 0);
            else
                q = make_request(3'($urandom_range(7)), 8'($urandom_range(255)),
                                 $urandom_range(32767), $urandom_range(32767),
                                 $urandom_range(32767), $urandom_range(32767));
            send_request(q);
        end
    endtask

    // receiver holds off while queries pile up against the output register
    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (3000)
                    @(posedge clk);
                hold_off = 1'b0;
            end
            begin
                for (int n = 0; n < 12; n++)
                    send_request(make_request(CMD_QUERY, stack_ids[n % stack_depth],
                                              0, 0, 0, 0));
            end
        join
    endtask

    task automatic drain();
        go_idle();
        while (expected_answers.size() > 0)
            @(posedge clk);
        repeat (400)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_backpressure();
        send_idle_pct = 37;
        recv_idle_pct = 85;
        test_random(450);
        send_idle_pct = 85;
        recv_idle_pct = 37;
        test_random(450);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(400);
        drain();

        $display("ran %0d requests, checked %0d query answers across idle mixes",
                 request_count, answer_count);
        if (fail_count == 0 && expected_answers.size() == 0)
            $display("window_stack_visible_area_core verification clean");
        else
            $display("window_stack_visible_area_core verification failed");
        $finish;
    end

endmodule

`default_nettype wire
